// File: hdl/angle_wrap_direction_vector_assert.svh
// Assertion macros for the angle wrap and direction vector block.
// Expects signals named clock and reset in the including module.
`ifndef ANGLE_WRAP_DIRECTION_VECTOR_ASSERT_SVH
`define ANGLE_WRAP_DIRECTION_VECTOR_ASSERT_SVH

// Same-cycle implication, masked while reset is high.
`define AWDV_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, active during reset as well.
`define AWDV_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) (ante) |=> (cons)) else $error(msg);

`endif

// File: hdl/awdv_pkg.sv
// Shared types, constants and CORDIC helpers for the angle wrap block.
// No dependencies; every module imports this package.
package awdv_pkg;

   localparam int IN_W    = 18;
   localparam int OUT_W   = 16;
   localparam int X_W     = 33;   // CORDIC x and y, Q30 with headroom
   localparam int Z_W     = 34;   // CORDIC residual angle, Q30
   localparam int PROD_W  = 66;   // Q60 products
   localparam int RND_W   = 67;   // rounding word
   localparam int MAX_STAGES = 24;

   localparam longint TWO_PI_Q32  = 64'sd26986075409;
   localparam longint HALF_PI_Q30 = 64'sd1686629713;

   localparam logic [Z_W-1:0] HALF_PI_1 = Z_W'(HALF_PI_Q30);
   localparam logic [Z_W-1:0] HALF_PI_2 = Z_W'(2 * HALF_PI_Q30);
   localparam logic [Z_W-1:0] HALF_PI_3 = Z_W'(3 * HALF_PI_Q30);

   // Start value: inverse gain of an unbounded CORDIC, Q30
   localparam logic signed [X_W-1:0] GAIN_Q30 = 33'sd652032874;

   // atan(2^-i) in Q30, truncated
   localparam logic [31:0] ATAN_Q30 [MAX_STAGES] = '{
      32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76,
      32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD,
      32'h000FFFFF, 32'h0007FFFF, 32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF,
      32'h00007FFF, 32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
      32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F
   };

   typedef logic signed [X_W-1:0] cval_type;
   typedef logic signed [Z_W-1:0] zval_type;

   typedef enum logic [1:0] {
      QUAD_FIRST  = 2'd0,
      QUAD_SECOND = 2'd1,
      QUAD_THIRD  = 2'd2,
      QUAD_FOURTH = 2'd3
   } quad_type;

   typedef struct packed {
      cval_type x;
      cval_type y;
      zval_type z;
   } cordic_type;

   // Per-transaction control and passenger data along the pipeline
   typedef struct packed {
      logic             valid;
      logic             flag;
      quad_type         yaw_quad;
      quad_type         pitch_quad;
      logic [OUT_W-1:0] yaw;
      logic [OUT_W-1:0] pitch;
      logic [OUT_W-1:0] roll;
   } meta_type;

   // Full turn at the given number of fraction bits, rounded
   function automatic longint awdv_two_pi(input int afb);
      return (TWO_PI_Q32 + (longint'(1) <<< (31 - afb))) >>> (32 - afb);
   endfunction

   // One CORDIC rotation toward zero residual angle
   function automatic cordic_type cordic_rotate(input cordic_type c, input int stage);
      cval_type   x;
      cval_type   y;
      zval_type   z;
      cval_type   dx;
      cval_type   dy;
      zval_type   da;
      cordic_type r;
      x  = c.x;
      y  = c.y;
      z  = c.z;
      dx = y >>> stage;
      dy = x >>> stage;
      da = zval_type'(ATAN_Q30[stage]);
      if (z[Z_W-1] == 1'b0) begin
         r.x = x - dx;
         r.y = y + dy;
         r.z = z - da;
      end else begin
         r.x = x + dx;
         r.y = y - dy;
         r.z = z + da;
      end
      return r;
   endfunction

endpackage

// File: hdl/awdv_reduce.sv
// Front end: wraps the three angles, then reduces yaw and pitch to a quadrant.
// Two register stages; depends on awdv_pkg.
module awdv_reduce import awdv_pkg::*; #(
   parameter int ANGLE_FRAC_BITS = 13
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   advance,
   input  logic                   in_valid,
   input  logic signed [IN_W-1:0] yaw_angle,
   input  logic signed [IN_W-1:0] pitch_angle,
   input  logic signed [IN_W-1:0] roll_angle,
   output meta_type               meta_out,
   output cordic_type             yaw_out,
   output cordic_type             pitch_out
);

   localparam longint TWO_PI  = awdv_two_pi(ANGLE_FRAC_BITS);
   localparam int     ANG_W   = $clog2(TWO_PI);
   localparam int     SUM_W   = ((ANG_W > IN_W - 1) ? ANG_W : IN_W - 1) + 2;
   localparam int     Z_SHIFT = 30 - ANGLE_FRAC_BITS;
   localparam logic signed [SUM_W-1:0] TP_S = SUM_W'(TWO_PI);

   // Wrap once, then clamp; returns {clamped, angle}
   function automatic logic [ANG_W:0] wrap_one(input logic signed [IN_W-1:0] raw);
      logic signed [SUM_W-1:0] a;
      logic                    flag;
      a    = SUM_W'(raw);
      flag = 1'b0;
      if (a >= TP_S) a = a - TP_S;
      if (a < 0) a = a + TP_S;
      if (a < 0) begin
         a    = '0;
         flag = 1'b1;
      end else if (a >= TP_S) begin
         a    = TP_S - SUM_W'(1);
         flag = 1'b1;
      end
      return {flag, a[ANG_W-1:0]};
   endfunction

   // Move to Q30 and strip whole quarter turns, at most three
   function automatic void reduce_quad(input logic [ANG_W-1:0] ang,
                                       output quad_type q, output zval_type z);
      logic [Z_W-1:0] zf;
      zf = Z_W'(ang) << Z_SHIFT;
      priority if (zf >= HALF_PI_3) begin
         q = QUAD_FOURTH;
         z = zval_type'(zf - HALF_PI_3);
      end else if (zf >= HALF_PI_2) begin
         q = QUAD_THIRD;
         z = zval_type'(zf - HALF_PI_2);
      end else if (zf >= HALF_PI_1) begin
         q = QUAD_SECOND;
         z = zval_type'(zf - HALF_PI_1);
      end else begin
         q = QUAD_FIRST;
         z = zval_type'(zf);
      end
   endfunction

   logic [ANG_W:0]   yaw_w;
   logic [ANG_W:0]   pitch_w;
   logic [ANG_W:0]   roll_w;

   logic             s1_valid_ff;
   logic             s1_flag_ff;
   logic             s1_flag_in;
   logic [ANG_W-1:0] s1_yaw_ff;
   logic [ANG_W-1:0] s1_pitch_ff;
   logic [ANG_W-1:0] s1_roll_ff;

   meta_type         meta_ff;
   meta_type         meta_in;
   cordic_type       yaw_ff;
   cordic_type       yaw_in;
   cordic_type       pitch_ff;
   cordic_type       pitch_in;
   quad_type         yaw_q;
   quad_type         pitch_q;
   zval_type         yaw_z;
   zval_type         pitch_z;

   // Wrap all three angles
   always_comb begin
      yaw_w      = wrap_one(yaw_angle);
      pitch_w    = wrap_one(pitch_angle);
      roll_w     = wrap_one(roll_angle);
      s1_flag_in = yaw_w[ANG_W] | pitch_w[ANG_W] | roll_w[ANG_W];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= in_valid;
         s1_flag_ff  <= s1_flag_in;
         s1_yaw_ff   <= yaw_w[ANG_W-1:0];
         s1_pitch_ff <= pitch_w[ANG_W-1:0];
         s1_roll_ff  <= roll_w[ANG_W-1:0];
      end
   end

   // Quadrant reduction and CORDIC seed
   always_comb begin
      reduce_quad(s1_yaw_ff, yaw_q, yaw_z);
      reduce_quad(s1_pitch_ff, pitch_q, pitch_z);
      meta_in.valid      = s1_valid_ff;
      meta_in.flag       = s1_flag_ff;
      meta_in.yaw_quad   = yaw_q;
      meta_in.pitch_quad = pitch_q;
      meta_in.yaw        = OUT_W'(s1_yaw_ff);
      meta_in.pitch      = OUT_W'(s1_pitch_ff);
      meta_in.roll       = OUT_W'(s1_roll_ff);
      yaw_in.x           = GAIN_Q30;
      yaw_in.y           = '0;
      yaw_in.z           = yaw_z;
      pitch_in.x         = GAIN_Q30;
      pitch_in.y         = '0;
      pitch_in.z         = pitch_z;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         meta_ff.valid <= 1'b0;
      end else if (advance) begin
         meta_ff  <= meta_in;
         yaw_ff   <= yaw_in;
         pitch_ff <= pitch_in;
      end
   end

   assign meta_out  = meta_ff;
   assign yaw_out   = yaw_ff;
   assign pitch_out = pitch_ff;

endmodule

// File: hdl/awdv_cordic_stage.sv
// One registered CORDIC iteration, applied to yaw and pitch side by side.
// Depends on awdv_pkg for the rotation and the arctangent table.
module awdv_cordic_stage import awdv_pkg::*; #(
   parameter int STAGE = 0
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       advance,
   input  meta_type   meta_in,
   input  cordic_type yaw_in,
   input  cordic_type pitch_in,
   output meta_type   meta_out,
   output cordic_type yaw_out,
   output cordic_type pitch_out
);

   meta_type   meta_ff;
   cordic_type yaw_ff;
   cordic_type yaw_rot_in;
   cordic_type pitch_ff;
   cordic_type pitch_rot_in;

   // Rotate both vectors by this stage's step
   always_comb begin
      yaw_rot_in   = cordic_rotate(yaw_in, STAGE);
      pitch_rot_in = cordic_rotate(pitch_in, STAGE);
   end

   // Advance with the pipeline, hold on stall
   always_ff @(posedge clock) begin
      if (reset) begin
         meta_ff.valid <= 1'b0;
      end else if (advance) begin
         meta_ff  <= meta_in;
         yaw_ff   <= yaw_rot_in;
         pitch_ff <= pitch_rot_in;
      end
   end

   assign meta_out  = meta_ff;
   assign yaw_out   = yaw_ff;
   assign pitch_out = pitch_ff;

endmodule

// File: hdl/awdv_finish.sv
// Back end: quadrant fix-up, products, then rounding and saturation.
// Three register stages; depends on awdv_pkg.
module awdv_finish import awdv_pkg::*; #(
   parameter int OUT_FRAC_BITS = 14
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    advance,
   input  meta_type                meta_in,
   input  cordic_type              yaw_in,
   input  cordic_type              pitch_in,
   output meta_type                meta_out,
   output logic signed [OUT_W-1:0] dir_x,
   output logic signed [OUT_W-1:0] dir_y,
   output logic signed [OUT_W-1:0] dir_z
);

   localparam int PROD_SHIFT = 60 - OUT_FRAC_BITS;
   localparam int NEG_SHIFT  = 30 - OUT_FRAC_BITS;
   localparam logic signed [RND_W-1:0] LIM = RND_W'(1) <<< OUT_FRAC_BITS;

   // Undo the quadrant reduction
   function automatic void quad_fix(input cordic_type c, input quad_type q,
                                    output cval_type s, output cval_type co);
      unique case (q)
         QUAD_FIRST: begin
            s  = c.y;
            co = c.x;
         end
         QUAD_SECOND: begin
            s  = c.x;
            co = -c.y;
         end
         QUAD_THIRD: begin
            s  = -c.y;
            co = -c.x;
         end
         QUAD_FOURTH: begin
            s  = -c.x;
            co = c.y;
         end
         default: begin
            s  = c.y;
            co = c.x;
         end
      endcase
   endfunction

   // Round half up, saturate to one unit, keep the low output bits
   function automatic logic [OUT_W-1:0] round_sat(input logic signed [RND_W-1:0] v,
                                                  input int sh);
      logic signed [RND_W-1:0] r;
      r = (v + (RND_W'(1) <<< (sh - 1))) >>> sh;
      if (r > LIM) begin
         r = LIM;
      end else if (r < -LIM) begin
         r = -LIM;
      end
      return r[OUT_W-1:0];
   endfunction

   meta_type                 f1_meta_ff;
   cval_type                 sy_ff;
   cval_type                 sy_in;
   cval_type                 cy_ff;
   cval_type                 cy_in;
   cval_type                 sp_ff;
   cval_type                 sp_in;
   cval_type                 cp_ff;
   cval_type                 cp_in;

   meta_type                 f2_meta_ff;
   logic signed [PROD_W-1:0] px_ff;
   logic signed [PROD_W-1:0] px_in;
   logic signed [PROD_W-1:0] pz_ff;
   logic signed [PROD_W-1:0] pz_in;
   logic signed [X_W:0]      ny_ff;
   logic signed [X_W:0]      ny_in;

   meta_type                 f3_meta_ff;
   logic [OUT_W-1:0]         dx_ff;
   logic [OUT_W-1:0]         dx_in;
   logic [OUT_W-1:0]         dy_ff;
   logic [OUT_W-1:0]         dy_in;
   logic [OUT_W-1:0]         dz_ff;
   logic [OUT_W-1:0]         dz_in;

   // Stage one: sine and cosine in their true quadrant
   always_comb begin
      quad_fix(yaw_in, meta_in.yaw_quad, sy_in, cy_in);
      quad_fix(pitch_in, meta_in.pitch_quad, sp_in, cp_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f1_meta_ff.valid <= 1'b0;
      end else if (advance) begin
         f1_meta_ff <= meta_in;
         sy_ff      <= sy_in;
         cy_ff      <= cy_in;
         sp_ff      <= sp_in;
         cp_ff      <= cp_in;
      end
   end

   // Stage two: Q60 products and the negated pitch sine
   always_comb begin
      px_in = PROD_W'(cp_ff) * PROD_W'(cy_ff);
      pz_in = PROD_W'(cp_ff) * PROD_W'(sy_ff);
      ny_in = -((X_W + 1)'(sp_ff));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f2_meta_ff.valid <= 1'b0;
      end else if (advance) begin
         f2_meta_ff <= f1_meta_ff;
         px_ff      <= px_in;
         pz_ff      <= pz_in;
         ny_ff      <= ny_in;
      end
   end

   // Stage three: round and saturate into the output register
   always_comb begin
      dx_in = round_sat(RND_W'(px_ff), PROD_SHIFT);
      dz_in = round_sat(RND_W'(pz_ff), PROD_SHIFT);
      dy_in = round_sat(RND_W'(ny_ff), NEG_SHIFT);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f3_meta_ff.valid <= 1'b0;
      end else if (advance) begin
         f3_meta_ff <= f2_meta_ff;
         dx_ff      <= dx_in;
         dy_ff      <= dy_in;
         dz_ff      <= dz_in;
      end
   end

   assign meta_out = f3_meta_ff;
   assign dir_x    = dx_ff;
   assign dir_y    = dy_ff;
   assign dir_z    = dz_ff;

endmodule

// File: hdl/angle_wrap_direction_vector.sv
// Pipeline from accept to result, in order:
// two front-end stages, one per CORDIC iteration, three back-end stages.
// Throughput: one transaction per cycle; the whole pipeline holds while a
// finished result is stalled, set by the single shared advance enable.
// Reset: synchronous, clears every stage valid bit; payload is not reset.
`include "angle_wrap_direction_vector_assert.svh"

module angle_wrap_direction_vector import awdv_pkg::*; #(
   parameter int ANGLE_FRAC_BITS = 13,
   parameter int OUT_FRAC_BITS   = 14,
   parameter int CORDIC_STAGES   = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic signed [IN_W-1:0]  req_yaw_angle,
   input  logic signed [IN_W-1:0]  req_pitch_angle,
   input  logic signed [IN_W-1:0]  req_roll_angle,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [OUT_W-1:0]        rsp_yaw_wrapped,
   output logic [OUT_W-1:0]        rsp_pitch_wrapped,
   output logic [OUT_W-1:0]        rsp_roll_wrapped,
   output logic signed [OUT_W-1:0] rsp_dir_x,
   output logic signed [OUT_W-1:0] rsp_dir_y,
   output logic signed [OUT_W-1:0] rsp_dir_z,
   output logic                    rsp_out_of_range
);

   localparam longint TWO_PI    = awdv_two_pi(ANGLE_FRAC_BITS);
   localparam bit     TP_FITS   = TWO_PI <= 65535;
   localparam logic [OUT_W:0] TP_CMP = (OUT_W + 1)'(TWO_PI);
   localparam bit     UNIT_FITS = OUT_FRAC_BITS <= 14;
   localparam logic signed [OUT_W-1:0] UNIT = OUT_W'(longint'(1) <<< OUT_FRAC_BITS);

   logic       advance;
   meta_type   stage_meta  [CORDIC_STAGES+1];
   cordic_type stage_yaw   [CORDIC_STAGES+1];
   cordic_type stage_pitch [CORDIC_STAGES+1];
   meta_type   out_meta;
   logic       wrap_chk;
   logic       wrap_ok;
   logic       dir_chk;
   logic       dir_ok;

   // Move every stage unless the result register is stalled
   assign advance   = !(rsp_valid && rsp_stall);
   assign req_stall = !advance;

   awdv_reduce #(
      .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)
   ) u_reduce (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .in_valid   (req_valid),
      .yaw_angle  (req_yaw_angle),
      .pitch_angle(req_pitch_angle),
      .roll_angle (req_roll_angle),
      .meta_out   (stage_meta[0]),
      .yaw_out    (stage_yaw[0]),
      .pitch_out  (stage_pitch[0])
   );

   // Unrolled CORDIC, one iteration per stage
   for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_cordic
      awdv_cordic_stage #(
         .STAGE(k)
      ) u_stage (
         .clock    (clock),
         .reset    (reset),
         .advance  (advance),
         .meta_in  (stage_meta[k]),
         .yaw_in   (stage_yaw[k]),
         .pitch_in (stage_pitch[k]),
         .meta_out (stage_meta[k+1]),
         .yaw_out  (stage_yaw[k+1]),
         .pitch_out(stage_pitch[k+1])
      );
   end

   awdv_finish #(
      .OUT_FRAC_BITS(OUT_FRAC_BITS)
   ) u_finish (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .meta_in (stage_meta[CORDIC_STAGES]),
      .yaw_in  (stage_yaw[CORDIC_STAGES]),
      .pitch_in(stage_pitch[CORDIC_STAGES]),
      .meta_out(out_meta),
      .dir_x   (rsp_dir_x),
      .dir_y   (rsp_dir_y),
      .dir_z   (rsp_dir_z)
   );

   // Drive the result channel from the last stage
   assign rsp_valid         = out_meta.valid;
   assign rsp_yaw_wrapped   = out_meta.yaw;
   assign rsp_pitch_wrapped = out_meta.pitch;
   assign rsp_roll_wrapped  = out_meta.roll;
   assign rsp_out_of_range  = out_meta.flag;

   // Range checks on the result fields
   assign wrap_chk = rsp_valid && TP_FITS;
   assign wrap_ok  = ({1'b0, rsp_yaw_wrapped} < TP_CMP) &&
                     ({1'b0, rsp_pitch_wrapped} < TP_CMP) &&
                     ({1'b0, rsp_roll_wrapped} < TP_CMP);
   assign dir_chk  = rsp_valid && UNIT_FITS;
   assign dir_ok   = (rsp_dir_x >= -UNIT) && (rsp_dir_x <= UNIT) &&
                     (rsp_dir_z >= -UNIT) && (rsp_dir_z <= UNIT);

   `AWDV_ASSERT_NEXT(a_reset_clears_output, reset, !rsp_valid, "result valid after reset")
   `AWDV_ASSERT_SAME(a_wrapped_below_turn, wrap_chk, wrap_ok, "wrapped angle beyond a turn")
   `AWDV_ASSERT_SAME(a_dir_saturated, dir_chk, dir_ok, "direction component beyond one unit")

endmodule
